>>> rtl/x86_integer_alu_with_flags_macros.svh
// assertion macros used by the checker file
`ifndef X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define XALU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define XALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/xalu_pkg.sv
// ----------------------------------------------------------------------------
// xalu_pkg
// Shared codes, controller/datapath interface types and width helpers of
// the x86 integer alu.
// ----------------------------------------------------------------------------
package xalu_pkg;

  // operation codes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_CMP   = 4'd2;
  localparam logic [3:0] OP_INC   = 4'd3;
  localparam logic [3:0] OP_DEC   = 4'd4;
  localparam logic [3:0] OP_NEG   = 4'd5;
  localparam logic [3:0] OP_ADC   = 4'd6;
  localparam logic [3:0] OP_SBB   = 4'd7;
  localparam logic [3:0] OP_MUL   = 4'd8;
  localparam logic [3:0] OP_IMUL1 = 4'd9;
  localparam logic [3:0] OP_IMUL2 = 4'd10;
  localparam logic [3:0] OP_IMUL3 = 4'd11;
  localparam logic [3:0] OP_DIV   = 4'd12;
  localparam logic [3:0] OP_IDIV  = 4'd13;

  // operand width codes (code three behaves as doubleword)
  localparam logic [1:0] WC_BYTE  = 2'd0;
  localparam logic [1:0] WC_WORD  = 2'd1;
  localparam logic [1:0] WC_DWORD = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic fin;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_div;
    logic pre_err;
    logic div_last;
  } dp_status_t;

  // operand mask at width
  function automatic logic [31:0] width_mask(input logic [1:0] wc);
    logic [31:0] m;
    case (wc)
      WC_BYTE: m = 32'h0000_00ff;
      WC_WORD: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // sign bit at width
  function automatic logic [31:0] width_msb(input logic [1:0] wc);
    logic [31:0] m;
    case (wc)
      WC_BYTE: m = 32'h0000_0080;
      WC_WORD: m = 32'h0000_8000;
      default: m = 32'h8000_0000;
    endcase
    return m;
  endfunction

  // sign extension from width to 33 bits
  function automatic logic [32:0] sext33(input logic [31:0] v, input logic [1:0] wc);
    logic [32:0] r;
    case (wc)
      WC_BYTE: r = {{25{v[7]}}, v[7:0]};
      WC_WORD: r = {{17{v[15]}}, v[15:0]};
      default: r = {v[31], v};
    endcase
    return r;
  endfunction

endpackage

>>> rtl/xalu_ctrl.sv
// ----------------------------------------------------------------------------
// xalu_ctrl
// Sequencer of the alu: load, execute, divide iterations, finish, hand off.
// ----------------------------------------------------------------------------
module xalu_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  xalu_pkg::dp_status_t  status_i,
  output xalu_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.is_div && !status_i.pre_err) state_d = S_DIV;
        else state_d = S_DONE;
      end
      S_DIV: begin
        if (status_i.div_last) state_d = S_FIN;
      end
      S_FIN: state_d = S_DONE;
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // handshake and datapath commands
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign cmd_o.load  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign cmd_o.step  = (state_q == S_DIV);
  assign cmd_o.fin   = (state_q == S_FIN);

endmodule

>>> rtl/xalu_dp.sv
// ----------------------------------------------------------------------------
// xalu_dp
// Datapath of the alu: operand registers, adder, multiplier, radix-2
// divider, flags register and result registers.
// ----------------------------------------------------------------------------
module xalu_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xalu_pkg::ctrl_cmd_t   cmd_i,
  output xalu_pkg::dp_status_t  status_o,
  input  logic [3:0]            operation_i,
  input  logic [1:0]            width_code_i,
  input  logic [31:0]           dest_value_i,
  input  logic [31:0]           src_value_i,
  input  logic [31:0]           src2_value_i,
  input  logic [31:0]           acc_low_i,
  input  logic [31:0]           acc_high_i,
  output logic [31:0]           result_low_o,
  output logic [31:0]           result_high_o,
  output logic                  write_dest_o,
  output logic                  write_high_o,
  output logic                  carry_out_o,
  output logic                  overflow_out_o,
  output logic                  zero_out_o,
  output logic                  sign_out_o,
  output logic                  divide_error_o
);

  logic [3:0]  op_q;
  logic [1:0]  wc_q;
  logic [31:0] d_q, s_q, s2_q, al_q, ah_q;
  logic        cf_q, of_q, zf_q, sf_q;
  logic [31:0] lo_q, hi_q;
  logic        wd_q, wh_q, de_q;
  logic [31:0] rem_q, dvs_q, num_q, quo_q;
  logic [4:0]  cnt_q;
  logic        nneg_q, dneg_q, sdiv_q;

  logic [31:0] m, msb, d, s, s2, al, ah;

  // operand capture on an accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      wc_q <= width_code_i;
      d_q  <= dest_value_i;
      s_q  <= src_value_i;
      s2_q <= src2_value_i;
      al_q <= acc_low_i;
      ah_q <= acc_high_i;
    end
  end

  assign m   = xalu_pkg::width_mask(wc_q);
  assign msb = xalu_pkg::width_msb(wc_q);
  assign d   = d_q & m;
  assign s   = s_q & m;
  assign s2  = s2_q & m;
  assign al  = al_q & m;
  assign ah  = ah_q & m;

  // adder and subtractor
  logic [32:0] add_t, sub_v, diff_t;
  logic        add_cy, sub_bw;
  assign add_t  = {1'b0, d} + {1'b0, s} + {32'b0, (op_q == xalu_pkg::OP_ADC) & cf_q};
  assign sub_v  = {1'b0, s} + {32'b0, (op_q == xalu_pkg::OP_SBB) & cf_q};
  assign diff_t = {1'b0, d} - sub_v;
  assign sub_bw = ({1'b0, d} < sub_v);

  always_comb begin
    case (wc_q)
      xalu_pkg::WC_BYTE: add_cy = add_t[8];
      xalu_pkg::WC_WORD: add_cy = add_t[16];
      default:           add_cy = add_t[32];
    endcase
  end

  // shared signed 33x33 multiplier, unsigned forms zero extended
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [63:0]        p;
  logic [31:0]        p_lo, p_hi;
  always_comb begin
    case (op_q)
      xalu_pkg::OP_MUL: begin
        mul_a = $signed({1'b0, d});
        mul_b = $signed({1'b0, al});
      end
      xalu_pkg::OP_IMUL1: begin
        mul_a = $signed(xalu_pkg::sext33(d, wc_q));
        mul_b = $signed(xalu_pkg::sext33(al, wc_q));
      end
      xalu_pkg::OP_IMUL3: begin
        mul_a = $signed(xalu_pkg::sext33(s2, wc_q));
        mul_b = $signed(xalu_pkg::sext33(s, wc_q));
      end
      default: begin
        mul_a = $signed(xalu_pkg::sext33(d, wc_q));
        mul_b = $signed(xalu_pkg::sext33(s, wc_q));
      end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign p    = prod[63:0];
  assign p_lo = p[31:0] & m;
  always_comb begin
    case (wc_q)
      xalu_pkg::WC_BYTE: p_hi = {24'b0, p[15:8]};
      xalu_pkg::WC_WORD: p_hi = {16'b0, p[31:16]};
      default:           p_hi = p[63:32];
    endcase
  end

  // divider setup: magnitudes, high half and left-aligned low half
  logic        is_div, is_idiv, nneg, dneg, pre_err;
  logic [63:0] n64, mask2, nm;
  logic [31:0] dm, nm_hi, nm_lo;
  assign is_idiv = (op_q == xalu_pkg::OP_IDIV);
  assign is_div  = (op_q == xalu_pkg::OP_DIV) || is_idiv;
  assign nneg    = is_idiv && ((ah & msb) != 32'b0);
  assign dneg    = is_idiv && ((d & msb) != 32'b0);
  always_comb begin
    case (wc_q)
      xalu_pkg::WC_BYTE: begin
        n64   = {48'b0, ah[7:0], al[7:0]};
        mask2 = 64'h0000_0000_0000_ffff;
      end
      xalu_pkg::WC_WORD: begin
        n64   = {32'b0, ah[15:0], al[15:0]};
        mask2 = 64'h0000_0000_ffff_ffff;
      end
      default: begin
        n64   = {ah, al};
        mask2 = 64'hffff_ffff_ffff_ffff;
      end
    endcase
  end
  assign nm = nneg ? ((~n64 + 64'd1) & mask2) : n64;
  assign dm = dneg ? ((~d + 32'd1) & m) : d;
  always_comb begin
    case (wc_q)
      xalu_pkg::WC_BYTE: begin
        nm_hi = {24'b0, nm[15:8]};
        nm_lo = {nm[7:0], 24'b0};
      end
      xalu_pkg::WC_WORD: begin
        nm_hi = {16'b0, nm[31:16]};
        nm_lo = {nm[15:0], 16'b0};
      end
      default: begin
        nm_hi = nm[63:32];
        nm_lo = nm[31:0];
      end
    endcase
  end
  // a quotient of more than width bits shows as high half not below divisor
  assign pre_err = (d == 32'b0) || (nm_hi >= dm);

  // combinational results and flags, and the early divide error
  logic [31:0] lo_c, hi_c;
  logic        wd_c, wh_c, de_c, cf_c, of_c, zf_c, sf_c, ov_c;
  always_comb begin
    lo_c = '0;
    hi_c = '0;
    wd_c = 1'b0;
    wh_c = 1'b0;
    de_c = 1'b0;
    cf_c = cf_q;
    of_c = of_q;
    zf_c = zf_q;
    sf_c = sf_q;
    ov_c = (p_hi != (((p_lo & msb) != 32'b0) ? m : 32'b0));
    case (op_q)
      xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
        lo_c = add_t[31:0] & m;
        cf_c = add_cy;
        of_c = ((~(d ^ s) & (d ^ lo_c) & msb) != 32'b0);
        wd_c = 1'b1;
      end
      xalu_pkg::OP_SUB, xalu_pkg::OP_CMP, xalu_pkg::OP_SBB: begin
        lo_c = diff_t[31:0] & m;
        cf_c = sub_bw;
        of_c = (((d ^ s) & (d ^ lo_c) & msb) != 32'b0);
        wd_c = (op_q != xalu_pkg::OP_CMP);
      end
      xalu_pkg::OP_INC: begin
        lo_c = (d + 32'd1) & m;
        wd_c = 1'b1;
      end
      xalu_pkg::OP_DEC: begin
        lo_c = (d - 32'd1) & m;
        wd_c = 1'b1;
      end
      xalu_pkg::OP_NEG: begin
        lo_c = (~d + 32'd1) & m;
        cf_c = (d != 32'b0);
        wd_c = 1'b1;
      end
      xalu_pkg::OP_MUL, xalu_pkg::OP_IMUL3: begin
        lo_c = p_lo;
        hi_c = p_hi;
        wd_c = 1'b1;
        wh_c = (op_q == xalu_pkg::OP_MUL);
      end
      xalu_pkg::OP_IMUL1, xalu_pkg::OP_IMUL2: begin
        lo_c = p_lo;
        hi_c = p_hi;
        wd_c = 1'b1;
        wh_c = (op_q == xalu_pkg::OP_IMUL1);
        cf_c = ov_c;
        of_c = ov_c;
      end
      xalu_pkg::OP_DIV, xalu_pkg::OP_IDIV: begin
        // only latched here on a divide error
        de_c = 1'b1;
      end
      default: ;
    endcase
    // zf and sf from the low result for the flag-setting groups
    case (op_q)
      xalu_pkg::OP_ADD, xalu_pkg::OP_SUB, xalu_pkg::OP_CMP, xalu_pkg::OP_INC,
      xalu_pkg::OP_DEC, xalu_pkg::OP_NEG, xalu_pkg::OP_ADC, xalu_pkg::OP_SBB,
      xalu_pkg::OP_IMUL1, xalu_pkg::OP_IMUL2: begin
        zf_c = (lo_c == 32'b0);
        sf_c = ((lo_c & msb) != 32'b0);
      end
      default: ;
    endcase
  end

  // radix-2 restoring divide step
  logic [32:0] shifted;
  logic        ge;
  logic [32:0] sub_r;
  assign shifted = {rem_q, num_q[31]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign sub_r   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rem_q  <= nm_hi;
      dvs_q  <= dm;
      num_q  <= nm_lo;
      quo_q  <= '0;
      nneg_q <= nneg;
      dneg_q <= dneg;
      sdiv_q <= is_idiv;
      case (wc_q)
        xalu_pkg::WC_BYTE: cnt_q <= 5'd7;
        xalu_pkg::WC_WORD: cnt_q <= 5'd15;
        default:           cnt_q <= 5'd31;
      endcase
    end else if (cmd_i.step) begin
      rem_q <= ge ? sub_r[31:0] : shifted[31:0];
      quo_q <= {quo_q[30:0], ge};
      num_q <= {num_q[30:0], 1'b0};
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // signed fix-up of quotient and remainder
  logic        qneg, fin_err;
  logic [31:0] q_fix, r_fix;
  assign qneg    = nneg_q ^ dneg_q;
  assign fin_err = sdiv_q && (qneg ? (quo_q > msb) : (quo_q > (msb - 32'd1)));
  assign q_fix   = qneg ? ((~quo_q + 32'd1) & m) : quo_q;
  assign r_fix   = nneg_q ? ((~rem_q + 32'd1) & m) : rem_q;

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !(is_div && !pre_err)) begin
      lo_q <= lo_c;
      hi_q <= hi_c;
      wd_q <= wd_c;
      wh_q <= wh_c;
      de_q <= de_c;
    end else if (cmd_i.fin) begin
      lo_q <= fin_err ? 32'b0 : q_fix;
      hi_q <= fin_err ? 32'b0 : r_fix;
      wd_q <= !fin_err;
      wh_q <= !fin_err;
      de_q <= fin_err;
    end
  end

  // flags register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q <= 1'b0;
      of_q <= 1'b0;
      zf_q <= 1'b0;
      sf_q <= 1'b0;
    end else if (cmd_i.exec) begin
      cf_q <= cf_c;
      of_q <= of_c;
      zf_q <= zf_c;
      sf_q <= sf_c;
    end
  end

  assign status_o.is_div   = is_div;
  assign status_o.pre_err  = pre_err;
  assign status_o.div_last = (cnt_q == 5'd0);

  assign result_low_o   = lo_q;
  assign result_high_o  = hi_q;
  assign write_dest_o   = wd_q;
  assign write_high_o   = wh_q;
  assign divide_error_o = de_q;
  assign carry_out_o    = cf_q;
  assign overflow_out_o = of_q;
  assign zero_out_o     = zf_q;
  assign sign_out_o     = sf_q;

endmodule

>>> rtl/x86_integer_alu_with_flags.sv
// One operation at a time: an accepted beat enters the execute state and, for
// a non-divide operation, its result is offered on the next cycle; no new
// beat is accepted until the result is taken. div and idiv run a radix-2
// restoring divider one quotient bit per cycle, followed by a fix-up step.
// A zero divisor or a quotient wider than the operand is found in the
// execute state and skips the iterations; a signed quotient out of range
// is caught in the fix-up. Flags CF, OF, ZF and SF reset to zero and are
// held between operations.
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags
// x86 add/sub/cmp/inc/dec/neg/adc/sbb/mul/imul/div/idiv unit with flags.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  operation_i,
  input  logic [1:0]  width_code_i,
  input  logic [31:0] dest_value_i,
  input  logic [31:0] src_value_i,
  input  logic [31:0] src2_value_i,
  input  logic [31:0] acc_low_i,
  input  logic [31:0] acc_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_low_o,
  output logic [31:0] result_high_o,
  output logic        write_dest_o,
  output logic        write_high_o,
  output logic        carry_out_o,
  output logic        overflow_out_o,
  output logic        zero_out_o,
  output logic        sign_out_o,
  output logic        divide_error_o
);

  xalu_pkg::ctrl_cmd_t  cmd;
  xalu_pkg::dp_status_t status;

  // sequencer
  xalu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  xalu_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (operation_i),
    .width_code_i   (width_code_i),
    .dest_value_i   (dest_value_i),
    .src_value_i    (src_value_i),
    .src2_value_i   (src2_value_i),
    .acc_low_i      (acc_low_i),
    .acc_high_i     (acc_high_i),
    .result_low_o   (result_low_o),
    .result_high_o  (result_high_o),
    .write_dest_o   (write_dest_o),
    .write_high_o   (write_high_o),
    .carry_out_o    (carry_out_o),
    .overflow_out_o (overflow_out_o),
    .zero_out_o     (zero_out_o),
    .sign_out_o     (sign_out_o),
    .divide_error_o (divide_error_o)
  );

endmodule

>>> rtl/xalu_checker.sv
// ----------------------------------------------------------------------------
// xalu_checker
// Port-level checks of the alu, bound to the top level.
// ----------------------------------------------------------------------------
`include "x86_integer_alu_with_flags_macros.svh"

module xalu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        write_dest_o,
  input logic        write_high_o,
  input logic        divide_error_o
);

  // a result beat waits for the consumer
  `XALU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // one operation in flight: no intake while a result is offered
  `XALU_ASSERT_NOW(a_one_inflight, out_valid_o, !in_ready_o)

  // an accepted beat closes the intake on the next cycle
  `XALU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // a divide error writes nothing back
  `XALU_ASSERT_NOW(a_de_no_write, out_valid_o && divide_error_o,
                   !write_dest_o && !write_high_o)

endmodule

bind x86_integer_alu_with_flags xalu_checker u_xalu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .write_dest_o   (write_dest_o),
  .write_high_o   (write_high_o),
  .divide_error_o (divide_error_o)
);
